// File: hdl/gzhp_pkg.sv
// Shared types for the gzip header parser: result kinds, error codes and result records.
// It has no dependencies. The parser core, the output queue and the top level use it.
package gzhp_pkg;

  typedef enum logic [1:0] {
    KIND_CHUNK = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_MAGIC     = 3'd0,
    ERR_METHOD    = 3'd1,
    ERR_RESERVED  = 3'd2,
    ERR_EXTRA     = 3'd3,
    ERR_RA        = 3'd4,
    ERR_TRUNCATED = 3'd5
  } err_e;

  typedef struct packed {
    kind_e       kind;
    err_e        error_code;
    logic [15:0] chunk_index;
    logic [15:0] chunk_size;
    logic [31:0] chunk_offset;
    logic [31:0] header_length;
    logic [15:0] chunk_length;
    logic [15:0] chunk_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    v0;
    result_t r0;
    logic    v1;
    result_t r1;
  } res_pair_t;

endpackage

// File: hdl/gzip_header_ra_parser.sv
// Top level of the gzip member header parser with random-access chunk table decoding.
// It depends on gzhp_pkg, gzhp_core and gzhp_outq.
//
//   Channel  Direction  Handshake                 Transaction payload
//   in       input      in_valid_i / in_stall_o   data_byte_i, end_of_input_i
//   out      output     out_valid_o / out_stall_i kind_o .. chunk_count_o, last_o
//
// A byte is registered at the edge that accepts it and processed once the output queue has room
// for two entries, so one byte is accepted every cycle while that room lasts; its results are
// written into the queue and offered from its head. A chunk entry with a final result takes two entries.
// The input stalls while a byte waits in the input register and the output queue has fewer
// than two free entries.
// Reset returns the parser to the first magic byte and empties the queue.
module gzip_header_ra_parser #(
  parameter int OUT_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  error_code_o,
  output logic [15:0] chunk_index_o,
  output logic [15:0] chunk_size_o,
  output logic [31:0] chunk_offset_o,
  output logic [31:0] header_length_o,
  output logic [15:0] chunk_length_o,
  output logic [15:0] chunk_count_o,
  output logic        last_o
);

  logic                in_vld_q;
  logic                in_vld_d;
  logic [7:0]          in_byte_q;
  logic                in_eoi_q;
  logic                take;
  logic                proc;
  logic                room;
  logic                pop;
  gzhp_pkg::res_pair_t pair;
  gzhp_pkg::result_t   head;

  assign proc       = in_vld_q & room;
  assign in_stall_o = in_vld_q & ~room;
  assign take       = in_valid_i & ~in_stall_o;
  assign pop        = out_valid_o & ~out_stall_i;

  always_comb begin
    in_vld_d = in_vld_q;
    if (take) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= data_byte_i;
      in_eoi_q  <= end_of_input_i;
    end
  end

  gzhp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .proc_i (proc),
    .byte_i (in_byte_q),
    .eoi_i  (in_eoi_q),
    .res_o  (pair)
  );

  gzhp_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (proc),
    .pair_i  (pair),
    .room_o  (room),
    .valid_o (out_valid_o),
    .pop_i   (pop),
    .head_o  (head)
  );

  assign kind_o          = head.kind;
  assign error_code_o    = head.error_code;
  assign chunk_index_o   = head.chunk_index;
  assign chunk_size_o    = head.chunk_size;
  assign chunk_offset_o  = head.chunk_offset;
  assign header_length_o = head.header_length;
  assign chunk_length_o  = head.chunk_length;
  assign chunk_count_o   = head.chunk_count;
  assign last_o          = head.last;

endmodule

// File: hdl/gzhp_core.sv
// Parser state and the per-byte next-state logic of the gzip header parser.
// It depends on gzhp_pkg. It produces up to two result records for each processed byte.
module gzhp_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               proc_i,
  input  logic [7:0]         byte_i,
  input  logic               eoi_i,
  output gzhp_pkg::res_pair_t res_o
);

  localparam logic [7:0] MAGIC_FIRST   = 8'h1f;
  localparam logic [7:0] MAGIC_SECOND  = 8'h8b;
  localparam logic [7:0] METHOD_DEFL   = 8'h08;
  localparam logic [7:0] FLAG_RESERVED = 8'hE0;
  localparam logic [4:0] FLAG_HCRC     = 5'h02;
  localparam logic [4:0] FLAG_EXTRA    = 5'h04;
  localparam logic [4:0] FLAG_NAME     = 5'h08;
  localparam logic [4:0] FLAG_COMMENT  = 5'h10;
  localparam logic [7:0] ID_R          = 8'h52;
  localparam logic [7:0] ID_A          = 8'h41;

  typedef enum logic [13:0] {
    PH_MAGIC1  = 14'h0001,
    PH_MAGIC2  = 14'h0002,
    PH_METHOD  = 14'h0004,
    PH_FLAGS   = 14'h0008,
    PH_FIXED   = 14'h0010,
    PH_XLEN    = 14'h0020,
    PH_SUBHDR  = 14'h0040,
    PH_SKIPSUB = 14'h0080,
    PH_RAHDR   = 14'h0100,
    PH_RACHUNK = 14'h0200,
    PH_NAME    = 14'h0400,
    PH_COMMENT = 14'h0800,
    PH_HCRC    = 14'h1000,
    PH_IDLE    = 14'h2000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  fbc;
    logic [7:0]  hold;
    logic [4:0]  flags;
    logic [15:0] extra_rem;
    logic [15:0] sub_rem;
    logic [7:0]  id_first;
    logic [7:0]  id_second;
    logic [15:0] ra_version;
    logic [15:0] ra_len;
    logic [15:0] ra_cnt;
    logic [15:0] entry;
    logic [31:0] offset;
    logic [31:0] hcount;
  } state_t;

  function automatic state_t reset_state();
    state_t s;
    s = '0;
    s.phase = PH_MAGIC1;
    return s;
  endfunction

  function automatic gzhp_pkg::result_t zero_result();
    gzhp_pkg::result_t r;
    r = '0;
    return r;
  endfunction

  state_t              st_q;
  state_t              st_d;
  logic                bnd;
  logic                sec;
  logic [1:0]          lvl;
  logic                dn;
  logic                fl;
  gzhp_pkg::err_e      fcode;
  logic                ck;
  logic [15:0]         v16;
  logic [15:0]         er4;
  logic [15:0]         sub_m1;
  gzhp_pkg::result_t   ck_res;
  gzhp_pkg::result_t   fin_res;

  always_comb begin
    st_d   = st_q;
    bnd    = 1'b0;
    sec    = 1'b0;
    lvl    = 2'd0;
    dn     = 1'b0;
    fl     = 1'b0;
    fcode  = gzhp_pkg::ERR_MAGIC;
    ck     = 1'b0;
    v16    = {byte_i, st_q.hold};
    er4    = st_q.extra_rem - 16'd4;
    sub_m1 = st_q.sub_rem - 16'd1;
    if (eoi_i) begin
      fl    = (st_q.phase != PH_IDLE);
      fcode = gzhp_pkg::ERR_TRUNCATED;
    end else if (st_q.phase != PH_IDLE) begin
      if (st_q.hcount != '1) begin
        st_d.hcount = st_q.hcount + 32'd1;
      end
      case (st_q.phase)
        PH_MAGIC1: begin
          if (byte_i != MAGIC_FIRST) begin
            fl = 1'b1;
          end else begin
            st_d.phase = PH_MAGIC2;
          end
        end
        PH_MAGIC2: begin
          if (byte_i != MAGIC_SECOND) begin
            fl = 1'b1;
          end else begin
            st_d.phase = PH_METHOD;
          end
        end
        PH_METHOD: begin
          st_d.hold  = byte_i;
          st_d.phase = PH_FLAGS;
        end
        PH_FLAGS: begin
          if (st_q.hold != METHOD_DEFL) begin
            fl    = 1'b1;
            fcode = gzhp_pkg::ERR_METHOD;
          end else if ((byte_i & FLAG_RESERVED) != 8'd0) begin
            fl    = 1'b1;
            fcode = gzhp_pkg::ERR_RESERVED;
          end else begin
            st_d.flags = byte_i[4:0];
            st_d.fbc   = 3'd0;
            st_d.phase = PH_FIXED;
          end
        end
        PH_FIXED: begin
          st_d.fbc = st_q.fbc + 3'd1;
          if (st_d.fbc >= 3'd6) begin
            st_d.fbc = 3'd0;
            if ((st_q.flags & FLAG_EXTRA) != 5'd0) begin
              st_d.phase = PH_XLEN;
            end else begin
              sec = 1'b1;
              lvl = 2'd0;
            end
          end
        end
        PH_XLEN: begin
          if (st_q.fbc == 3'd0) begin
            st_d.hold = byte_i;
            st_d.fbc  = 3'd1;
          end else begin
            st_d.extra_rem = v16;
            bnd            = 1'b1;
          end
        end
        PH_SUBHDR: begin
          case (st_q.fbc)
            3'd0: begin
              st_d.id_first = byte_i;
              st_d.fbc      = 3'd1;
            end
            3'd1: begin
              st_d.id_second = byte_i;
              st_d.fbc       = 3'd2;
            end
            3'd2: begin
              st_d.hold = byte_i;
              st_d.fbc  = 3'd3;
            end
            default: begin
              st_d.extra_rem = er4;
              if (v16 > er4) begin
                fl    = 1'b1;
                fcode = gzhp_pkg::ERR_EXTRA;
              end else begin
                st_d.extra_rem = er4 - v16;
                st_d.sub_rem   = v16;
                st_d.fbc       = 3'd0;
                if (st_q.id_first == ID_R && st_q.id_second == ID_A) begin
                  if (v16 < 16'd6) begin
                    fl    = 1'b1;
                    fcode = gzhp_pkg::ERR_RA;
                  end else begin
                    st_d.phase = PH_RAHDR;
                  end
                end else if (v16 == 16'd0) begin
                  bnd = 1'b1;
                end else begin
                  st_d.phase = PH_SKIPSUB;
                end
              end
            end
          endcase
        end
        PH_SKIPSUB: begin
          st_d.sub_rem = sub_m1;
          if (sub_m1 == 16'd0) begin
            bnd = 1'b1;
          end
        end
        PH_RAHDR: begin
          st_d.sub_rem = sub_m1;
          if (!st_q.fbc[0]) begin
            st_d.hold = byte_i;
            st_d.fbc  = st_q.fbc + 3'd1;
          end else if (st_q.fbc == 3'd1) begin
            st_d.ra_version = v16;
            st_d.fbc        = 3'd2;
          end else if (st_q.fbc == 3'd3) begin
            st_d.ra_len = v16;
            st_d.fbc    = 3'd4;
          end else begin
            st_d.ra_cnt = v16;
            st_d.fbc    = 3'd0;
            if (st_q.ra_version != 16'd1 || {1'b0, sub_m1} != {v16, 1'b0}) begin
              fl    = 1'b1;
              fcode = gzhp_pkg::ERR_RA;
            end else begin
              st_d.entry  = 16'd0;
              st_d.offset = 32'd0;
              if (v16 == 16'd0) begin
                bnd = 1'b1;
              end else begin
                st_d.phase = PH_RACHUNK;
              end
            end
          end
        end
        PH_RACHUNK: begin
          st_d.sub_rem = sub_m1;
          if (st_q.fbc == 3'd0) begin
            st_d.hold = byte_i;
            st_d.fbc  = 3'd1;
          end else begin
            st_d.fbc    = 3'd0;
            ck          = 1'b1;
            st_d.offset = st_q.offset + {16'd0, v16};
            st_d.entry  = st_q.entry + 16'd1;
            if (sub_m1 == 16'd0) begin
              bnd = 1'b1;
            end
          end
        end
        PH_NAME: begin
          if (byte_i == 8'd0) begin
            sec = 1'b1;
            lvl = 2'd1;
          end
        end
        PH_COMMENT: begin
          if (byte_i == 8'd0) begin
            sec = 1'b1;
            lvl = 2'd2;
          end
        end
        PH_HCRC: begin
          st_d.fbc = st_q.fbc + 3'd1;
          if (st_d.fbc >= 3'd2) begin
            sec = 1'b1;
            lvl = 2'd3;
          end
        end
        default: begin
          st_d.phase = PH_IDLE;
        end
      endcase
    end

    if (bnd) begin
      if (st_d.extra_rem == 16'd0) begin
        sec = 1'b1;
        lvl = 2'd0;
      end else if (st_d.extra_rem <= 16'd4) begin
        fl    = 1'b1;
        fcode = gzhp_pkg::ERR_EXTRA;
      end else begin
        st_d.phase = PH_SUBHDR;
        st_d.fbc   = 3'd0;
      end
    end

    if (sec) begin
      st_d.fbc = 3'd0;
      if (lvl < 2'd1 && (st_d.flags & FLAG_NAME) != 5'd0) begin
        st_d.phase = PH_NAME;
      end else if (lvl < 2'd2 && (st_d.flags & FLAG_COMMENT) != 5'd0) begin
        st_d.phase = PH_COMMENT;
      end else if (lvl < 2'd3 && (st_d.flags & FLAG_HCRC) != 5'd0) begin
        st_d.phase = PH_HCRC;
      end else begin
        dn         = 1'b1;
        st_d.phase = PH_IDLE;
      end
    end

    if (fl) begin
      st_d.phase = PH_IDLE;
    end

    ck_res              = zero_result();
    ck_res.kind         = gzhp_pkg::KIND_CHUNK;
    ck_res.chunk_index  = st_q.entry;
    ck_res.chunk_size   = v16;
    ck_res.chunk_offset = st_q.offset;
    ck_res.chunk_length = st_q.ra_len;
    ck_res.chunk_count  = st_q.ra_cnt;

    fin_res = zero_result();
    if (fl) begin
      fin_res.kind       = gzhp_pkg::KIND_ERROR;
      fin_res.error_code = fcode;
    end else begin
      fin_res.kind          = gzhp_pkg::KIND_DONE;
      fin_res.header_length = st_d.hcount;
      fin_res.chunk_length  = st_d.ra_len;
      fin_res.chunk_count   = st_d.ra_cnt;
    end

    res_o.v0 = ck | dn | fl;
    res_o.r0 = ck ? ck_res : fin_res;
    res_o.v1 = ck & (dn | fl);
    res_o.r1 = fin_res;
    res_o.r0.last = !res_o.v1;
    res_o.r1.last = 1'b1;

    if (eoi_i) begin
      st_d = reset_state();
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= reset_state();
    end else if (proc_i) begin
      st_q <= st_d;
    end
  end

`ifndef ASSERT_OFF
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q.phase))
    else $error("parser phase is not one-hot");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_i && res_o.v1) |-> (res_o.r0.kind == gzhp_pkg::KIND_CHUNK && !res_o.r0.last))
    else $error("second result without a chunk entry before it");

  a_final_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_i && !eoi_i && res_o.v0 && (res_o.v1 || res_o.r0.kind != gzhp_pkg::KIND_CHUNK))
    |=> (st_q.phase == PH_IDLE))
    else $error("parser did not idle after done or error");
`endif

endmodule

// File: hdl/gzhp_outq.sv
// Output queue of the gzip header parser; it accepts up to two result records per cycle.
// It depends on gzhp_pkg. It parts the parser from a stalled output channel.
module gzhp_outq #(
  parameter int DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gzhp_pkg::res_pair_t pair_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                pop_i,
  output gzhp_pkg::result_t   head_o
);

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  gzhp_pkg::result_t mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  wr_ptr_d;
  logic [PTR_W-1:0]  wr_ptr1;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_d;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_d;
  logic              push0;
  logic              push1;

  assign push0   = push_i & pair_i.v0;
  assign push1   = push_i & pair_i.v1;
  assign wr_ptr1 = ptr_inc(wr_ptr_q);
  assign room_o  = (count_q <= CNT_W'(DEPTH - 2));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push1) begin
      wr_ptr_d = ptr_inc(wr_ptr1);
    end else if (push0) begin
      wr_ptr_d = wr_ptr1;
    end
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (push0 && wr_ptr_q == PTR_W'(i)) begin
        mem_q[i] <= pair_i.r0;
      end else if (push1 && wr_ptr1 == PTR_W'(i)) begin
        mem_q[i] <= pair_i.r1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o)
    else $error("result pair pushed without room for two entries");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty result queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("result queue count exceeds its depth");
`endif

endmodule
